/* design/sm83_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm83_pkg
// Shared types and constants for the SM83 instruction executor.
// ----------------------------------------------------------------------------
package sm83_pkg;

  typedef enum logic [4:0] {
    K_NOP, K_DI, K_LD_RR, K_LD_RD8, K_LD_PD16, K_INC16, K_DEC16, K_INCDEC8,
    K_SUB, K_AND, K_XOR, K_CP, K_ST_HL, K_LDH_ST, K_LD_ST16, K_LD_A_MEM,
    K_JR, K_JP, K_JP_HL, K_CALL, K_ILLEGAL
  } kind_t;

  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_DI   = 8'hF3;
  localparam logic [7:0] OP_CP   = 8'hFE;
  localparam logic [7:0] OP_JPHL = 8'hE9;
  localparam logic [7:0] OP_CALL = 8'hCD;
  localparam logic [7:0] OP_JP   = 8'hC3;
  localparam logic [7:0] OP_JR   = 8'h18;
  localparam logic [7:0] OP_LDI  = 8'h22;
  localparam logic [7:0] OP_LDH_W = 8'hE0;
  localparam logic [7:0] OP_LD_W  = 8'hEA;
  localparam logic [7:0] OP_LDH_R = 8'hF0;
  localparam logic [7:0] OP_LD_R  = 8'hFA;
  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  // decoded transaction handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  dst;      // hi3
    logic [2:0]  src;      // lo3
    logic [1:0]  pair;
    logic        uncond;
    logic        is_dec;   // DEC / HL-
    logic [1:0]  len;
    logic [15:0] imm;
    logic [7:0]  load_data;
  } dec_t;

endpackage
`default_nettype wire

/* design/sm83_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm83_decode
// Front end: classifies opcodes and buffers decoded transactions in a
// two-entry queue.
// ----------------------------------------------------------------------------
module sm83_decode import sm83_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_op,
  input  wire logic [15:0] in_imm,
  input  wire logic [7:0]  in_load_data,
  output logic             q_valid,
  input  wire logic        q_ready,
  output dec_t             q_data
);

  dec_t d;
  dec_t mem_r [2];
  logic rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] hi3, lo3;

  assign hi3 = in_op[5:3];
  assign lo3 = in_op[2:0];

  always_comb begin
    d = '0;
    d.kind = K_ILLEGAL;
    d.dst = hi3;
    d.src = lo3;
    d.pair = in_op[5:4];
    d.uncond = 1'b0;
    d.is_dec = 1'b0;
    d.len = 2'd1;
    d.imm = in_imm;
    d.load_data = in_load_data;
    if (in_op == OP_NOP) d.kind = K_NOP;
    else if (in_op == OP_DI) d.kind = K_DI;
    else if (in_op[7:6] == 2'b01) begin
      if (hi3 != 3'd6 && lo3 != 3'd6) d.kind = K_LD_RR;
    end else if ((in_op & 8'hC7) == 8'h06) begin
      if (hi3 != 3'd6) begin
        d.kind = K_LD_RD8; d.len = 2'd2;
      end
    end else if ((in_op & 8'hCF) == 8'h01) begin
      d.kind = K_LD_PD16; d.len = 2'd3;
    end else if ((in_op & 8'hCF) == 8'h03) d.kind = K_INC16;
    else if ((in_op & 8'hCF) == 8'h0B) d.kind = K_DEC16;
    else if ((in_op & 8'hC6) == 8'h04) begin
      if (hi3 != 3'd6) begin
        d.kind = K_INCDEC8; d.is_dec = in_op[0];
      end
    end else if (in_op[7:3] == 5'b10010) begin
      if (lo3 != 3'd6) d.kind = K_SUB;
    end else if (in_op[7:4] == 4'hA) begin
      if (lo3 != 3'd6) d.kind = in_op[3] ? K_XOR : K_AND;
    end else if (in_op == OP_CP) begin
      d.kind = K_CP; d.len = 2'd2;
    end else if (in_op == OP_LDI || in_op == 8'h32) begin
      d.kind = K_ST_HL; d.is_dec = in_op[4];
    end else if (in_op == OP_LDH_W) begin
      d.kind = K_LDH_ST; d.len = 2'd2;
    end else if (in_op == OP_LD_W) begin
      d.kind = K_LD_ST16; d.len = 2'd3;
    end else if (in_op == OP_LDH_R) begin
      d.kind = K_LD_A_MEM; d.len = 2'd2;
    end else if (in_op == OP_LD_R) begin
      d.kind = K_LD_A_MEM; d.len = 2'd3;
    end else if (in_op == OP_JR || in_op == 8'h20 || in_op == 8'h28 ||
                 in_op == 8'h30 || in_op == 8'h38) begin
      d.kind = K_JR; d.len = 2'd2; d.uncond = (in_op == OP_JR);
    end else if (in_op == OP_JP || in_op == 8'hC2 || in_op == 8'hCA ||
                 in_op == 8'hD2 || in_op == 8'hDA) begin
      d.kind = K_JP; d.len = 2'd3; d.uncond = (in_op == OP_JP);
    end else if (in_op == OP_JPHL) d.kind = K_JP_HL;
    else if (in_op == OP_CALL || in_op == 8'hC4 || in_op == 8'hCC ||
             in_op == 8'hD4 || in_op == 8'hDC) begin
      d.kind = K_CALL; d.len = 2'd3; d.uncond = (in_op == OP_CALL);
    end
    d.pair = in_op[5:4];
    if (d.kind == K_JR || d.kind == K_JP || d.kind == K_CALL) d.pair = {1'b0, hi3[1]};
    d.src = (d.kind == K_JR || d.kind == K_JP || d.kind == K_CALL) ?
            {2'b00, hi3[0]} : lo3;
  end

  logic push, pop;
  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = mem_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= d;
  end

endmodule
`default_nettype wire

/* design/sm83_exec.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm83_exec
// Back end: architectural registers, ALU, branch unit and output register.
// A taken CALL occupies the output stage for two transactions.
// ----------------------------------------------------------------------------
module sm83_exec import sm83_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  output logic              q_ready,
  input  dec_t              q_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [15:0]       out_af,
  output logic [15:0]       out_bc,
  output logic [15:0]       out_de,
  output logic [15:0]       out_hl,
  output logic [15:0]       out_stack_ptr,
  output logic [15:0]       out_prog_counter,
  output logic              out_write_en,
  output logic [15:0]       out_write_addr,
  output logic [7:0]        out_write_data,
  output logic              out_last,
  output logic              out_illegal,
  output logic              out_int_enable
);

  logic [7:0] a_r, a_nxt;
  logic [3:0] f_r, f_nxt;
  logic [7:0] gp_r [6];
  logic [7:0] gp_nxt [6];
  logic [15:0] sp_r, sp_nxt, pc_r, pc_nxt;
  logic ime_r, ime_nxt;

  logic ov_r;                // output register holds a transaction
  logic pend_r;              // second CALL write waiting
  logic [15:0] pend_addr_r;
  logic [7:0]  pend_data_r;
  logic we_r, last_r, ill_r;
  logic [15:0] wa_r;
  logic [7:0] wd_r;

  logic take;
  assign q_ready = !pend_r && (!ov_r || out_ready);
  assign take = q_valid && q_ready;

  function automatic logic [7:0] rd8(input logic [2:0] r, input logic [7:0] a,
                                     input logic [7:0] g [6]);
    logic [7:0] v;
    case (r)
      3'd0: v = g[0];
      3'd1: v = g[1];
      3'd2: v = g[2];
      3'd3: v = g[3];
      3'd4: v = g[4];
      3'd5: v = g[5];
      3'd7: v = a;
      default: v = g[0];
    endcase
    return v;
  endfunction

  logic [7:0] src8, dst8, res8, d8;
  logic [15:0] rr, rr_new, hl, pc1, npc, off;
  logic cond, ok, we, call;
  logic [15:0] wa;
  logic [7:0] wd;

  always_comb begin
    for (int i = 0; i < 6; i++) gp_nxt[i] = gp_r[i];
    a_nxt = a_r; f_nxt = f_r; sp_nxt = sp_r; ime_nxt = ime_r;
    d8 = q_data.imm[7:0];
    src8 = rd8(q_data.src, a_r, gp_r);
    dst8 = rd8(q_data.dst, a_r, gp_r);
    hl = {gp_r[4], gp_r[5]};
    case (q_data.pair)
      2'd0: rr = {gp_r[0], gp_r[1]};
      2'd1: rr = {gp_r[2], gp_r[3]};
      2'd2: rr = hl;
      default: rr = sp_r;
    endcase
    case (q_data.src[0] ? {q_data.pair[0], 1'b1} : {q_data.pair[0], 1'b0})
      2'b00: cond = !f_r[3];
      2'b01: cond = f_r[3];
      2'b10: cond = !f_r[0];
      default: cond = f_r[0];
    endcase
    cond = cond || q_data.uncond;
    pc1 = pc_r + {14'd0, q_data.len};
    npc = pc1;
    off = {{8{d8[7]}}, d8};
    ok = 1'b1; we = 1'b0; call = 1'b0; wa = '0; wd = '0;
    rr_new = rr;
    res8 = '0;
    case (q_data.kind)
      K_NOP: ;
      K_DI: ime_nxt = 1'b0;
      K_LD_RR, K_LD_RD8, K_LD_A_MEM: begin
        res8 = (q_data.kind == K_LD_RR) ? src8 :
               (q_data.kind == K_LD_RD8) ? d8 : q_data.load_data;
        if (q_data.kind == K_LD_A_MEM) a_nxt = res8;
        else if (q_data.dst == 3'd7) a_nxt = res8;
        else gp_nxt[q_data.dst] = res8;
      end
      K_LD_PD16, K_INC16, K_DEC16: begin
        rr_new = (q_data.kind == K_LD_PD16) ? q_data.imm :
                 (q_data.kind == K_INC16) ? rr + 16'd1 : rr - 16'd1;
        if (q_data.pair == 2'd3) sp_nxt = rr_new;
        else begin
          gp_nxt[{q_data.pair, 1'b0}] = rr_new[15:8];
          gp_nxt[{q_data.pair, 1'b1}] = rr_new[7:0];
        end
      end
      K_INCDEC8: begin
        res8 = q_data.is_dec ? dst8 - 8'd1 : dst8 + 8'd1;
        f_nxt = {res8 == 8'd0, q_data.is_dec,
                 q_data.is_dec ? (dst8[3:0] == 4'd0) : (res8[3:0] == 4'd0), f_r[0]};
        if (q_data.dst == 3'd7) a_nxt = res8;
        else gp_nxt[q_data.dst] = res8;
      end
      K_SUB, K_CP: begin
        if (q_data.kind == K_CP) src8 = d8;
        res8 = a_r - src8;
        f_nxt = {res8 == 8'd0, 1'b1, a_r[3:0] < src8[3:0], a_r < src8};
        if (q_data.kind == K_SUB) a_nxt = res8;
      end
      K_AND: begin
        res8 = a_r & src8;
        a_nxt = res8;
        f_nxt = {res8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      K_XOR: begin
        res8 = a_r ^ src8;
        a_nxt = res8;
        f_nxt = {res8 == 8'd0, 3'b000};
      end
      K_ST_HL: begin
        we = 1'b1; wa = hl; wd = a_r;
        rr_new = q_data.is_dec ? hl - 16'd1 : hl + 16'd1;
        gp_nxt[4] = rr_new[15:8];
        gp_nxt[5] = rr_new[7:0];
      end
      K_LDH_ST: begin
        we = 1'b1; wa = HIGH_PAGE + {8'd0, d8}; wd = a_r;
      end
      K_LD_ST16: begin
        we = 1'b1; wa = q_data.imm; wd = a_r;
      end
      K_JR: if (cond) npc = pc1 + off;
      K_JP: if (cond) npc = q_data.imm;
      K_JP_HL: npc = hl;
      K_CALL: if (cond) begin
        call = 1'b1;
        sp_nxt = sp_r - 16'd2;
        npc = q_data.imm;
        we = 1'b1; wa = sp_r - 16'd1; wd = pc1[15:8];
      end
      default: ok = 1'b0;
    endcase
    pc_nxt = npc;
    if (!ok) begin
      for (int i = 0; i < 6; i++) gp_nxt[i] = gp_r[i];
      a_nxt = a_r; f_nxt = f_r; sp_nxt = sp_r; ime_nxt = ime_r; pc_nxt = pc_r;
      we = 1'b0; wa = '0; wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0; f_r <= '0; sp_r <= '0; pc_r <= '0; ime_r <= 1'b0;
      for (int i = 0; i < 6; i++) gp_r[i] <= '0;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (take) begin
        a_r <= a_nxt; f_r <= f_nxt; sp_r <= sp_nxt; pc_r <= pc_nxt; ime_r <= ime_nxt;
        for (int i = 0; i < 6; i++) gp_r[i] <= gp_nxt[i];
        ov_r <= 1'b1;
        pend_r <= call;
      end else if (out_ready && ov_r) begin
        ov_r <= pend_r;
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      we_r <= we; wa_r <= wa; wd_r <= wd;
      last_r <= !call; ill_r <= !ok;
      pend_addr_r <= sp_r - 16'd2;
      pend_data_r <= pc1[7:0];
    end else if (out_ready && ov_r && pend_r) begin
      we_r <= 1'b1; wa_r <= pend_addr_r; wd_r <= pend_data_r;
      last_r <= 1'b1; ill_r <= 1'b0;
    end
  end

  // register state shows post-instruction values
  assign out_valid = ov_r;
  assign out_af = {a_r, f_r, 4'd0};
  assign out_bc = {gp_r[0], gp_r[1]};
  assign out_de = {gp_r[2], gp_r[3]};
  assign out_hl = {gp_r[4], gp_r[5]};
  assign out_stack_ptr = sp_r;
  assign out_prog_counter = pc_r;
  assign out_int_enable = ime_r;
  assign out_write_en = we_r;
  assign out_write_addr = wa_r;
  assign out_write_data = wd_r;
  assign out_last = last_r;
  assign out_illegal = ill_r;

endmodule
`default_nettype wire

/* design/sm83_instruction_execute.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm83_instruction_execute
// SM83 instruction executor, one instruction per input transaction.
// ----------------------------------------------------------------------------
// Input channel (in_*): opcode, operand bytes and loaded byte, valid/ready.
// Output channel (out_*): register state after the instruction plus any bus
// write; one transaction per instruction, two for a taken CALL (high byte of
// the return address first, last set on the second).
// Input acceptance writes a decode queue entry; execute then moves it into
// the output register, which raises out_valid.
// Throughput: one instruction per cycle while out_ready is high; a taken CALL
// holds the execute stage until its low-byte stack write is emitted.
// A two-entry queue parts decode from execute; a stalled receiver fills it,
// then in_ready drops.
// Reset: all registers, flags, SP, PC and interrupt enable go to zero, and
// both queue and output register empty.
// Illegal opcodes give one transaction with illegal set and state unchanged.
// ----------------------------------------------------------------------------
module sm83_instruction_execute import sm83_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_op,
  input  wire logic [15:0] in_imm,
  input  wire logic [7:0]  in_load_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_af,
  output logic [15:0]      out_bc,
  output logic [15:0]      out_de,
  output logic [15:0]      out_hl,
  output logic [15:0]      out_stack_ptr,
  output logic [15:0]      out_prog_counter,
  output logic             out_write_en,
  output logic [15:0]      out_write_addr,
  output logic [7:0]       out_write_data,
  output logic             out_last,
  output logic             out_illegal,
  output logic             out_int_enable
);

  logic q_valid, q_ready;
  dec_t q_data;

  sm83_decode u_decode (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_imm, .in_load_data,
    .q_valid, .q_ready, .q_data
  );

  sm83_exec u_exec (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_af, .out_bc, .out_de, .out_hl,
    .out_stack_ptr, .out_prog_counter, .out_write_en, .out_write_addr,
    .out_write_data, .out_last, .out_illegal, .out_int_enable
  );

`ifndef SYNTHESIS
  a_flag_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_af[3:0] == 4'd0) else $error("flag low nibble not zero");
  a_ill_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> !out_write_en && out_last)
    else $error("illegal transaction carries a write");
  a_call_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last && out_write_en)
    else $error("call second write missing");
`endif

endmodule
`default_nettype wire
